// File: src/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg: shared types for the odd-even transposition sorter
// Holds the controller state encoding and the command bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package oets_pkg;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic load;       // shift a new element into entry 0
    logic phase;      // run one compare-and-swap phase
    logic phase_odd;  // 0: pairs (0,1),(2,3)...  1: pairs (1,2),(3,4)...
    logic shift_out;  // drop entry 0 and move the rest down
  } dp_cmd_t;

endpackage

// File: src/oets_datapath.sv
// ----------------------------------------------------------------------------
// oets_datapath: element register row with a parallel compare-and-swap array
// Loads elements by shifting up, sorts one phase per cycle and emits by
// shifting down, so entry 0 always holds the next result.
// ----------------------------------------------------------------------------
module oets_datapath
  import oets_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(MAX_ITEMS + 1)
) (
  input  logic             clk_i,
  input  dp_cmd_t          cmd_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [31:0]      value_i,
  output logic [31:0]      head_value_o
);

  logic [DATA_WIDTH-1:0] store_q [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] store_d [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] din;

  // Input is narrowed to the element width, or zero-extended when wider.
  // The head entry is sign-extended or cut back to the 32-bit output.
  if (DATA_WIDTH <= 32) begin : g_narrow
    assign din = value_i[DATA_WIDTH-1:0];
    if (DATA_WIDTH == 32) begin : g_eq
      assign head_value_o = store_q[0];
    end else begin : g_ext
      assign head_value_o = {{(32 - DATA_WIDTH){store_q[0][DATA_WIDTH-1]}}, store_q[0]};
    end
  end else begin : g_wide
    assign din          = {{(DATA_WIDTH - 32){1'b0}}, value_i};
    assign head_value_o = store_q[0][31:0];
  end

  always_comb begin
    store_d = store_q;
    if (cmd_i.load) begin
      store_d[0] = din;
      for (int i = 1; i < MAX_ITEMS; i++) begin
        store_d[i] = store_q[i-1];
      end
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        store_d[i] = store_q[i+1];
      end
    end else if (cmd_i.phase) begin
      // Each pair is disjoint within a phase, so all swaps happen together.
      for (int j = 0; j < MAX_ITEMS - 1; j++) begin
        if (((j % 2) == 1) == cmd_i.phase_odd && CNT_W'(j + 1) < count_i &&
            $signed(store_q[j]) > $signed(store_q[j+1])) begin
          store_d[j]   = store_q[j+1];
          store_d[j+1] = store_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

// File: src/oets_ctrl.sv
// ----------------------------------------------------------------------------
// oets_ctrl: sequencer for load, sort and emit
// Tracks the element count, the overflow flag and the phase count, and
// drives both stream handshakes.
// ----------------------------------------------------------------------------
module oets_ctrl
  import oets_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_last_o,
  output logic             out_overflow_o,
  output dp_cmd_t          cmd_o,
  output logic [CNT_W-1:0] count_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] phase_q, phase_d;
  logic             odd_q, odd_d;
  logic             dropped_q, dropped_d;
  logic             in_fire, out_fire, full;

  assign full     = (count_q == CNT_W'(MAX_ITEMS));
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign in_ready_o     = (state_q == ST_LOAD);
  assign out_valid_o    = (state_q == ST_EMIT);
  assign out_last_o     = (count_q == CNT_W'(1));
  assign out_overflow_o = dropped_q;
  assign count_o        = count_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    phase_d       = phase_q;
    odd_d         = odd_q;
    dropped_d     = dropped_q;
    cmd_o         = '0;
    cmd_o.phase_odd = odd_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
          if (in_last_i) begin
            phase_d = '0;
            odd_d   = 1'b0;
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        // n phases of odd-even transposition fully sort n elements.
        cmd_o.phase = 1'b1;
        odd_d       = ~odd_q;
        phase_d     = phase_q + CNT_W'(1);
        if (phase_q + CNT_W'(1) >= count_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd_o.shift_out = 1'b1;
          count_d         = count_q - CNT_W'(1);
          if (out_last_o) begin
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      phase_q   <= '0;
      odd_q     <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      odd_q     <= odd_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

// File: src/odd_even_transposition_sort.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sort: streaming sorter for signed values
//
// Input stream: one signed value per transaction on s_axis_tdata_i, with
// s_axis_tlast_i marking the last value of a set. Up to MAX_ITEMS values
// are held; values arriving while the store is full are dropped, and the
// set is then reported with the overflow flag.
// After the last transaction the block runs one compare-and-swap phase per
// cycle over a parallel comparator array, n phases for a set of n values,
// alternating even and odd neighbor pairs.
// Output stream: the n values in ascending order, one per transaction,
// m_axis_tlast_o on the final one and m_axis_tuser_o carrying the overflow
// flag on every one of them.
// A set of n values is loaded, sorted and emitted in turn. The input is not
// ready during the sort and emit steps; a stalled receiver simply holds the
// current result in place. Reset sets the element count to zero and clears
// the overflow flag.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort
  import oets_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);

  dp_cmd_t         cmd;
  logic [CntW-1:0] count;

  oets_ctrl #(
    .MAX_ITEMS(MAX_ITEMS),
    .CNT_W    (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_last_i     (s_axis_tlast_i),
    .in_ready_o    (s_axis_tready_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_last_o    (m_axis_tlast_o),
    .out_overflow_o(m_axis_tuser_o),
    .cmd_o         (cmd),
    .count_o       (count)
  );

  oets_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_W     (CntW)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .count_i     (count),
    .value_i     (s_axis_tdata_i),
    .head_value_o(m_axis_tdata_o)
  );

endmodule

// File: bench/odd_even_transposition_sort_tb.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_tb: self-checking bench for the streaming sorter
// Sends sets of signed values on the input stream, each closed by tlast. A
// behavioral sorter in the bench predicts the sorted result stream for each
// set, and every output transaction is checked against the oldest pending
// prediction. A directed table runs first, then a set that fills the store
// and overflows it, then back pressure, then random sets with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_tb;

  localparam int MaxItems    = 64;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;
  localparam int LongHold    = 300;
  localparam int RandItems   = 55;
  localparam int ReportMax   = 10;

  localparam logic [31:0] MaxPos = 32'h7fff_ffff;
  localparam logic [31:0] MinNeg = 32'h8000_0000;
  localparam logic [31:0] MinusOne = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        overflow;
  } sorted_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        typed;      // expected result written in this row
    logic [31:0] exp_value;
    logic        exp_last;
    logic        exp_ovf;
  } stim_row_t;

  localparam int DirRows = 18;
  localparam stim_row_t DirTable [DirRows] = '{
    // Single-value sets come back unchanged.
    '{MaxPos,       1'b1, 1'b1, MaxPos,   1'b1, 1'b0},
    '{MinNeg,       1'b1, 1'b1, MinNeg,   1'b1, 1'b0},
    '{32'd0,        1'b1, 1'b1, 32'd0,    1'b1, 1'b0},
    '{MinusOne,     1'b1, 1'b1, MinusOne, 1'b1, 1'b0},
    // Mixed signs including both extremes.
    '{32'd5,        1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'hffff_fffd, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MinNeg,       1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MaxPos,       1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'd0,        1'b1, 1'b0, 32'd0, 1'b0, 1'b0},
    // Equal values.
    '{32'd4,        1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'd4,        1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MinusOne,     1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'd4,        1'b1, 1'b0, 32'd0, 1'b0, 1'b0},
    // Two values in reverse order.
    '{MaxPos,       1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MinNeg,       1'b1, 1'b0, 32'd0, 1'b0, 1'b0},
    // Already sorted.
    '{32'd1,        1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'd2,        1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{32'd3,        1'b1, 1'b0, 32'd0, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // Predicted output transactions, oldest first.
  sorted_t sorted_expect[$];

  // Bench copy of the sorter state.
  logic signed [31:0] held_vals [MaxItems];
  int                 held_count;
  bit                 held_dropped;

  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left;
  bit          no_gaps;
  bit          hold_req;
  logic [31:0] prev_value;

  odd_even_transposition_sort dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("odd_even_transposition_sort_tb NOT OK");
      $finish;
    end
  end

  // Adds one value to the held set; on tlast, sorts the set with even and odd
  // compare-and-swap phases and returns the values it emits.
  function automatic void sorter_accept(input logic [31:0] v, input logic l,
                                        ref sorted_t res[$]);
    int r;
    int j;
    int k;
    logic signed [31:0] tmp;
    res.delete();
    if (held_count < MaxItems) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!l) return;
    for (r = 0; r < held_count; r++) begin
      for (j = 0; j + 1 < held_count; j += 2)
        if (held_vals[j] > held_vals[j+1]) begin
          tmp = held_vals[j]; held_vals[j] = held_vals[j+1]; held_vals[j+1] = tmp;
        end
      for (j = 1; j + 1 < held_count; j += 2)
        if (held_vals[j] > held_vals[j+1]) begin
          tmp = held_vals[j]; held_vals[j] = held_vals[j+1]; held_vals[j+1] = tmp;
        end
    end
    for (k = 0; k < held_count; k++)
      res.push_back('{value: held_vals[k], last: (k == held_count - 1),
                      overflow: held_dropped});
    held_count = 0;
    held_dropped = 1'b0;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = 32'($urandom_range(0, 31)) - 32'd16;
      3: begin
        case ($urandom_range(0, 3))
          0: v = MaxPos;
          1: v = MinNeg;
          2: v = 32'd0;
          default: v = MinusOne;
        endcase
      end
      default: v = prev_value;
    endcase
    prev_value = v;
    return v;
  endfunction

  // Offers one value, waits for its transaction, records the prediction and
  // then idles between bursts.
  task automatic offer(input logic [31:0] v, input logic l, input logic typed,
                       input sorted_t typed_res);
    sorted_t res[$];
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sorter_accept(v, l, res);
    if (typed) sorted_expect.push_back(typed_res);
    else foreach (res[i]) sorted_expect.push_back(res[i]);
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        repeat (gap) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk_i);
  endtask

  task automatic offer_set(input int n);
    for (int k = 0; k < n; k++)
      offer(rand_value(), k == n - 1, 1'b0, '0);
  endtask

  // Receiver: stretches of always ready, coin flips or one of two fixed patterns,
  // plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int stretch_left;
    int mode;
    int phase;
    bit hold_done;
    hold_left = 0;
    stretch_left = 0;
    mode = 0;
    phase = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        m_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode = $urandom_range(0, 3);
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (phase % 3) != 0;
          default: m_tready <= (phase % 5) == 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    sorted_t got;
    sorted_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = '{value: m_tdata, last: m_tlast, overflow: m_tuser};
      if (sorted_expect.size() == 0) begin
        err_count++;
        if (err_count <= ReportMax)
          $display("unexpected result: value %h last %b overflow %b",
                   got.value, got.last, got.overflow);
      end else begin
        want = sorted_expect.pop_front();
        if (got.value !== want.value || got.last !== want.last ||
            got.overflow !== want.overflow) begin
          err_count++;
          if (err_count <= ReportMax)
            $display("mismatch: value %h/%h last %b/%b overflow %b/%b (expected/actual)",
                     want.value, got.value, want.last, got.last,
                     want.overflow, got.overflow);
        end
      end
    end
  end

  initial begin : stimulus
    int rand_sent;
    int n;
    stim_row_t row;
    held_count = 0;
    held_dropped = 1'b0;
    burst_left = 1;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    prev_value = 32'd0;
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = 32'd0;
    s_tlast = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      row = DirTable[i];
      offer(row.value, row.last, row.typed,
            '{value: row.exp_value, last: row.exp_last, overflow: row.exp_ovf});
    end
    wait_drained();

    // The store fills up, then one value past capacity is dropped and the
    // closing transaction is dropped as well.
    offer_set(MaxItems + 2);
    wait_drained();

    // The receiver holds off while two sets arrive back to back, so the
    // block sits in its emit step with its input stalled.
    no_gaps = 1'b1;
    hold_req = 1'b1;
    offer_set(12);
    offer_set(9);
    no_gaps = 1'b0;
    wait_drained();

    rand_sent = 0;
    while (rand_sent < RandItems) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: n = $urandom_range(11, 30);
        default: n = $urandom_range(1, 10);
      endcase
      offer_set(n);
      rand_sent += n;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0 && sorted_expect.size() == 0) begin
      $display("odd_even_transposition_sort_tb OK");
    end else begin
      $display("odd_even_transposition_sort_tb NOT OK");
    end
    $finish;
  end

endmodule
